// ===== rtl/bitmap_frame_allocator_unit_macros.svh =====
// assertion helpers used by the allocator sequencer
`ifndef BITMAP_FRAME_ALLOCATOR_UNIT_MACROS_SVH
`define BITMAP_FRAME_ALLOCATOR_UNIT_MACROS_SVH

// condition holds at every clock edge out of reset
`define BFA_ASSERT_ALWAYS(label, c, r, cond) \
    label: assert property (@(posedge c) disable iff (!r) (cond)) \
        else $error("bfa: invariant violated");

// consequence holds in the same cycle as the antecedent
`define BFA_ASSERT_IMPLIES(label, c, r, ante, cons) \
    label: assert property (@(posedge c) disable iff (!r) (ante) |-> (cons)) \
        else $error("bfa: same-cycle implication violated");

// consequence holds in the cycle after the antecedent
`define BFA_ASSERT_NEXT(label, c, r, ante, cons) \
    label: assert property (@(posedge c) disable iff (!r) (ante) |=> (cons)) \
        else $error("bfa: next-cycle implication violated");

`endif

// ===== rtl/bfa_pkg.sv =====
package bfa_pkg;

    // default sizing
    localparam int unsigned DEF_MAX_FRAME_COUNT = 32768;
    localparam int unsigned DEF_FRAME_BYTES     = 4096;
    localparam int unsigned DEF_MAP_WORD_BITS   = 32;
    localparam int unsigned DEF_MAP_WORDS       =
        (DEF_MAX_FRAME_COUNT + DEF_MAP_WORD_BITS - 1) / DEF_MAP_WORD_BITS;

    // fixed field widths
    localparam int unsigned CFG_W   = 16;
    localparam int unsigned MODE_W  = 2;
    localparam int unsigned ADDR_W  = 32;
    localparam int unsigned FADDR_W = 27;
    localparam int unsigned COUNT_W = 16;

    // request kinds
    localparam logic [MODE_W-1:0] MODE_ALLOC   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FREE    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RESERVE = 2'd2;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [ADDR_W-1:0] addr;
    } bfa_req_t;

    typedef struct packed {
        logic [FADDR_W-1:0] frame_addr;
        logic               ok;
        logic [COUNT_W-1:0] used_count;
        logic [COUNT_W-1:0] free_count;
    } bfa_rsp_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_MODIFY,
        ST_DONE
    } bfa_state_t;

endpackage

// ===== rtl/bfa_map_ram.sv =====
module bfa_map_ram #(
    parameter int unsigned WORDS     = bfa_pkg::DEF_MAP_WORDS,
    parameter int unsigned WORD_BITS = bfa_pkg::DEF_MAP_WORD_BITS,
    localparam int unsigned AW       = (WORDS > 1) ? $clog2(WORDS) : 1
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [AW-1:0]        waddr,
    input  logic [WORD_BITS-1:0] wdata,
    input  logic                 re,
    input  logic [AW-1:0]        raddr,
    output logic [WORD_BITS-1:0] rdata
);

    logic [WORD_BITS-1:0] mem [WORDS];
    logic [WORD_BITS-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/bfa_seq.sv =====
module bfa_seq #(
    parameter int unsigned MAX_FRAME_COUNT = bfa_pkg::DEF_MAX_FRAME_COUNT,
    parameter int unsigned FRAME_BYTES     = bfa_pkg::DEF_FRAME_BYTES,
    parameter int unsigned MAP_WORD_BITS   = bfa_pkg::DEF_MAP_WORD_BITS,
    localparam int unsigned MAP_WORDS      =
        (MAX_FRAME_COUNT + MAP_WORD_BITS - 1) / MAP_WORD_BITS,
    localparam int unsigned WORD_AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [bfa_pkg::CFG_W-1:0]    total,
    input  logic                         req_valid,
    output logic                         req_ready,
    input  bfa_pkg::bfa_req_t            req,
    output logic                         rsp_valid,
    input  logic                         rsp_ready,
    output bfa_pkg::bfa_rsp_t            rsp,
    output logic                         mem_we,
    output logic [WORD_AW-1:0]           mem_waddr,
    output logic [MAP_WORD_BITS-1:0]     mem_wdata,
    output logic                         mem_re,
    output logic [WORD_AW-1:0]           mem_raddr,
    input  logic [MAP_WORD_BITS-1:0]     mem_rdata
);

    import bfa_pkg::*;

    `include "bitmap_frame_allocator_unit_macros.svh"

    // frame bytes and map word bits are powers of two
    localparam int unsigned BIT_W       = $clog2(MAP_WORD_BITS);
    localparam int unsigned FRAME_SHIFT = $clog2(FRAME_BYTES);
    localparam int unsigned FIX_W       = WORD_AW + BIT_W;
    localparam int unsigned CNT_W       = WORD_AW + 1;
    localparam int unsigned PROD_W      = FIX_W + FRAME_SHIFT;
    localparam int unsigned WIDE_W      = (PROD_W > FADDR_W) ? PROD_W : FADDR_W;

    bfa_state_t state_reg, state_next;
    logic [CNT_W-1:0]     word_cnt_reg, word_cnt_next;
    logic                 pend_reg, pend_next;
    logic [COUNT_W-1:0]   used_reg, used_next;
    logic                 rsp_valid_reg, rsp_valid_next;
    logic [WORD_AW-1:0]   eval_addr_reg, eval_addr_next;
    logic [MODE_W-1:0]    mode_reg, mode_next;
    logic [FIX_W-1:0]     frame_reg, frame_next;
    logic                 res_ok_reg, res_ok_next;
    logic [FIX_W-1:0]     res_frame_reg, res_frame_next;
    bfa_rsp_t             rsp_reg, rsp_next;

    logic [31:0]              total_w;
    logic [31:0]              scan_base;
    logic [31:0]              eval_base;
    logic                     issue_ok;
    logic [MAP_WORD_BITS-1:0] valid_mask;
    logic [MAP_WORD_BITS-1:0] cand;
    logic [BIT_W-1:0]         hit_idx;
    logic                     hit;
    logic [31:0]              req_frame;
    logic                     req_in_range;
    logic                     req_modifies;
    logic                     cur_bit;
    logic                     do_free;
    logic                     do_resv;
    logic                     slot_free;
    logic                     accept;
    logic                     clear_last;
    logic [WIDE_W-1:0]        faddr_wide;

    // handshake
    assign req_ready = (state_reg == ST_IDLE);
    assign accept    = req_valid && req_ready;
    assign slot_free = !rsp_valid_reg || rsp_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // scan addressing: next word to read and word whose data is on the ram output
    assign total_w    = 32'(total);
    assign scan_base  = 32'({word_cnt_reg, {BIT_W{1'b0}}});
    assign eval_base  = 32'({eval_addr_reg, {BIT_W{1'b0}}});
    assign issue_ok   = (scan_base < total_w);
    assign clear_last = (word_cnt_reg == CNT_W'(MAP_WORDS - 1));

    // frames of the evaluated word that lie below the total
    always_comb
    begin
        valid_mask = '0;
        for (int i = 0; i < MAP_WORD_BITS; i++)
        begin
            valid_mask[i] = ((eval_base + 32'(i)) < total_w);
        end
    end

    assign cand = ~mem_rdata & valid_mask;
    assign hit  = pend_reg && (|cand);

    // lowest free frame in the evaluated word
    always_comb
    begin
        hit_idx = '0;
        for (int i = MAP_WORD_BITS - 1; i >= 0; i--)
        begin
            if (cand[i])
            begin
                hit_idx = BIT_W'(i);
            end
        end
    end

    // free and reserve decode
    assign req_frame    = req.addr >> FRAME_SHIFT;
    assign req_in_range = (req_frame < total_w);
    assign req_modifies = ((req.mode == MODE_FREE) || (req.mode == MODE_RESERVE))
                          && req_in_range;
    assign cur_bit      = mem_rdata[frame_reg[BIT_W-1:0]];
    assign do_free      = (mode_reg == MODE_FREE) && cur_bit;
    assign do_resv      = (mode_reg == MODE_RESERVE) && !cur_bit;

    assign faddr_wide = WIDE_W'({res_frame_reg, {FRAME_SHIFT{1'b0}}});

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    priority if (req.mode == MODE_ALLOC)
                    begin
                        state_next = ST_SCAN;
                    end
                    else if (req_modifies)
                    begin
                        state_next = ST_MODIFY;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_SCAN:
            begin
                if (hit || !issue_ok)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_MODIFY:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // datapath, ram control and result
    always_comb
    begin
        word_cnt_next  = word_cnt_reg;
        pend_next      = pend_reg;
        used_next      = used_reg;
        eval_addr_next = eval_addr_reg;
        mode_next      = mode_reg;
        frame_next     = frame_reg;
        res_ok_next    = res_ok_reg;
        res_frame_next = res_frame_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        mem_we         = 1'b0;
        mem_waddr      = '0;
        mem_wdata      = '0;
        mem_re         = 1'b0;
        mem_raddr      = '0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we        = 1'b1;
                mem_waddr     = word_cnt_reg[WORD_AW-1:0];
                word_cnt_next = clear_last ? '0 : word_cnt_reg + CNT_W'(1);
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    mode_next      = req.mode;
                    frame_next     = req_frame[FIX_W-1:0];
                    res_ok_next    = 1'b0;
                    res_frame_next = '0;
                    word_cnt_next  = '0;
                    pend_next      = 1'b0;
                    if (req_modifies)
                    begin
                        mem_re    = 1'b1;
                        mem_raddr = req_frame[FIX_W-1:BIT_W];
                    end
                end
            end
            ST_SCAN:
            begin
                pend_next = 1'b0;
                if (hit)
                begin
                    mem_we         = 1'b1;
                    mem_waddr      = eval_addr_reg;
                    mem_wdata      = mem_rdata | (MAP_WORD_BITS'(1) << hit_idx);
                    used_next      = used_reg + COUNT_W'(1);
                    res_ok_next    = 1'b1;
                    res_frame_next = {eval_addr_reg, hit_idx};
                end
                else if (issue_ok)
                begin
                    mem_re         = 1'b1;
                    mem_raddr      = word_cnt_reg[WORD_AW-1:0];
                    pend_next      = 1'b1;
                    eval_addr_next = word_cnt_reg[WORD_AW-1:0];
                    word_cnt_next  = word_cnt_reg + CNT_W'(1);
                end
            end
            ST_MODIFY:
            begin
                mem_waddr = frame_reg[FIX_W-1:BIT_W];
                if (do_free)
                begin
                    mem_we      = 1'b1;
                    mem_wdata   = mem_rdata & ~(MAP_WORD_BITS'(1) << frame_reg[BIT_W-1:0]);
                    used_next   = used_reg - COUNT_W'(1);
                    res_ok_next = 1'b1;
                end
                else if (do_resv)
                begin
                    mem_we      = 1'b1;
                    mem_wdata   = mem_rdata | (MAP_WORD_BITS'(1) << frame_reg[BIT_W-1:0]);
                    used_next   = used_reg + COUNT_W'(1);
                    res_ok_next = 1'b1;
                end
            end
            ST_DONE:
            begin
                if (slot_free)
                begin
                    rsp_valid_next      = 1'b1;
                    rsp_next.frame_addr = faddr_wide[FADDR_W-1:0];
                    rsp_next.ok         = res_ok_reg;
                    rsp_next.used_count = used_reg;
                    rsp_next.free_count = (total > used_reg) ? total - used_reg : '0;
                end
            end
            default:
            begin
                word_cnt_next = '0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            word_cnt_reg  <= '0;
            pend_reg      <= 1'b0;
            used_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            word_cnt_reg  <= word_cnt_next;
            pend_reg      <= pend_next;
            used_reg      <= used_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        eval_addr_reg <= eval_addr_next;
        mode_reg      <= mode_next;
        frame_reg     <= frame_next;
        res_ok_reg    <= res_ok_next;
        res_frame_reg <= res_frame_next;
        rsp_reg       <= rsp_next;
    end

    // checks
    `BFA_ASSERT_ALWAYS(a_no_rw_clash, clk, rst_n, !(mem_we && mem_re))
    `BFA_ASSERT_IMPLIES(a_clear_writes_zero, clk, rst_n, state_reg == ST_CLEAR, mem_we && (mem_wdata == '0))
    `BFA_ASSERT_NEXT(a_used_unit_step, clk, rst_n, 1'b1, (used_reg == $past(used_reg)) || (used_reg == $past(used_reg) + 16'd1) || (used_reg == $past(used_reg) - 16'd1))
    `BFA_ASSERT_IMPLIES(a_hold_when_slot_busy, clk, rst_n, (state_reg == ST_DONE) && rsp_valid_reg && !rsp_ready, state_next == ST_DONE)
    `BFA_ASSERT_IMPLIES(a_write_only_on_change, clk, rst_n, mem_we && (state_reg != ST_CLEAR), res_ok_next)

endmodule

// ===== rtl/bitmap_frame_allocator_unit.sv =====
// channel    | direction | handshake            | payload
// -----------+-----------+----------------------+------------------------------
// request    | in        | req_valid/req_ready  | req: mode, addr
// response   | out       | rsp_valid/rsp_ready  | rsp: frame_addr, ok, counts
// config     | in        | cfg_we (no wait)     | cfg_wdata: frame_total
//
// alloc scans the map words up to the first free frame (at most frame_total /
// MAP_WORD_BITS rounded up, 1024 at default size), one word a cycle through the
// single read port of the map ram
// free and reserve in range go through read, modify-write and result; out of
// range requests and the unused mode go straight to the result
// after reset a clearing pass writes every map word, one per cycle, with
// req_ready low
// one request is in work at a time; the response register lets a new request
// in while the previous response is still stalled
module bitmap_frame_allocator_unit #(
    parameter int unsigned MAX_FRAME_COUNT = bfa_pkg::DEF_MAX_FRAME_COUNT,
    parameter int unsigned FRAME_BYTES     = bfa_pkg::DEF_FRAME_BYTES,
    parameter int unsigned MAP_WORD_BITS   = bfa_pkg::DEF_MAP_WORD_BITS
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [bfa_pkg::CFG_W-1:0] cfg_wdata,
    input  logic                      req_valid,
    output logic                      req_ready,
    input  bfa_pkg::bfa_req_t         req,
    output logic                      rsp_valid,
    input  logic                      rsp_ready,
    output bfa_pkg::bfa_rsp_t         rsp
);

    import bfa_pkg::*;

    localparam int unsigned MAP_WORDS =
        (MAX_FRAME_COUNT + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
    localparam int unsigned WORD_AW   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam logic [31:0] MAX_W     = 32'(MAX_FRAME_COUNT);

    logic [CFG_W-1:0]         frame_total_reg;
    logic [CFG_W-1:0]         total_eff;
    logic                     mem_we;
    logic [WORD_AW-1:0]       mem_waddr;
    logic [MAP_WORD_BITS-1:0] mem_wdata;
    logic                     mem_re;
    logic [WORD_AW-1:0]       mem_raddr;
    logic [MAP_WORD_BITS-1:0] mem_rdata;

    // frame count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_total_reg <= '0;
        end
        else if (cfg_we)
        begin
            frame_total_reg <= cfg_wdata;
        end
    end

    // totals above the map size act as the map size
    assign total_eff = (32'(frame_total_reg) > MAX_W) ? MAX_W[CFG_W-1:0] : frame_total_reg;

    // request sequencer
    bfa_seq #(
        .MAX_FRAME_COUNT (MAX_FRAME_COUNT),
        .FRAME_BYTES     (FRAME_BYTES),
        .MAP_WORD_BITS   (MAP_WORD_BITS)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .total     (total_eff),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    // usage bitmap
    bfa_map_ram #(
        .WORDS     (MAP_WORDS),
        .WORD_BITS (MAP_WORD_BITS)
    ) u_map (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule

// ===== tb/bitmap_frame_allocator_unit_tb.sv =====
module bitmap_frame_allocator_unit_tb;

    import bfa_pkg::*;

    localparam int unsigned MAP_FRAMES   = DEF_MAX_FRAME_COUNT;
    localparam int unsigned PAGE_BYTES   = DEF_FRAME_BYTES;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int unsigned HOLD_CYCLES  = 200;
    localparam int unsigned STALL_LIMIT  = 20000;
    localparam int unsigned PHASE_COUNT  = 9;
    localparam int unsigned PHASE_ITEMS  = 62;
    localparam int unsigned IDLE_PERCENT = 34;

    // predicts allocator responses and checks them in order
    class frame_map_scoreboard;
        bit [MAP_FRAMES-1:0] taken_map;
        int unsigned         taken_count;
        logic [CFG_W-1:0]    total_reg;
        bfa_rsp_t            predicted_rsps[$];
        int unsigned         mismatches;

        function void set_total(logic [CFG_W-1:0] value);
            total_reg = value;
        endfunction

        function int unsigned pending();
            return predicted_rsps.size();
        endfunction

        // work out the response to an accepted request and update the map
        function void apply_request(bfa_req_t r);
            int unsigned limit;
            int unsigned f;
            bfa_rsp_t    e;
            limit = (total_reg > MAP_FRAMES) ? MAP_FRAMES : total_reg;
            e = '0;
            if (r.mode == MODE_ALLOC) begin
                for (f = 0; f < limit; f++) begin
                    if (!taken_map[f]) begin
                        taken_map[f] = 1'b1;
                        taken_count++;
                        e.frame_addr = FADDR_W'(f * PAGE_BYTES);
                        e.ok = 1'b1;
                        break;
                    end
                end
            end else if (r.mode == MODE_FREE || r.mode == MODE_RESERVE) begin
                f = r.addr / PAGE_BYTES;
                if (f < limit) begin
                    if (r.mode == MODE_FREE && taken_map[f]) begin
                        taken_map[f] = 1'b0;
                        taken_count--;
                        e.ok = 1'b1;
                    end else if (r.mode == MODE_RESERVE && !taken_map[f]) begin
                        taken_map[f] = 1'b1;
                        taken_count++;
                        e.ok = 1'b1;
                    end
                end
            end
            e.used_count = COUNT_W'(taken_count);
            e.free_count = (limit > taken_count) ? COUNT_W'(limit - taken_count) : '0;
            predicted_rsps.push_back(e);
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $time, msg);
            mismatches++;
        endtask

        task check_response(bfa_rsp_t got);
            bfa_rsp_t e;
            if (predicted_rsps.size() == 0) begin
                report($sformatf("response with nothing outstanding: %h", got));
            end else begin
                e = predicted_rsps.pop_front();
                if (got.frame_addr !== e.frame_addr)
                    report($sformatf("frame_addr expected %h got %h", e.frame_addr,
                                     got.frame_addr));
                if (got.ok !== e.ok)
                    report($sformatf("ok expected %b got %b", e.ok, got.ok));
                if (got.used_count !== e.used_count)
                    report($sformatf("used_count expected %0d got %0d", e.used_count,
                                     got.used_count));
                if (got.free_count !== e.free_count)
                    report($sformatf("free_count expected %0d got %0d", e.free_count,
                                     got.free_count));
            end
        endtask
    endclass

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_wdata;
    logic             req_valid;
    logic             req_ready;
    bfa_req_t         req;
    logic             rsp_valid;
    logic             rsp_ready;
    bfa_rsp_t         rsp;

    logic             hold_rsp;
    logic             no_idle;
    logic [CFG_W-1:0] phase_totals [PHASE_COUNT];

    frame_map_scoreboard sb = new();

    bitmap_frame_allocator_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic bfa_req_t make_req(logic [MODE_W-1:0] m, logic [ADDR_W-1:0] a);
        bfa_req_t r;
        r.mode = m;
        r.addr = a;
        return r;
    endfunction

    // mostly well-formed requests near the low frames, some noise
    function automatic bfa_req_t random_request(int unsigned total);
        bfa_req_t    r;
        int unsigned pick;
        int unsigned near;
        int unsigned f;
        pick   = $urandom_range(0, 99);
        near   = (total < 200) ? total : 200;
        r.mode = MODE_ALLOC;
        r.addr = $urandom();
        if (pick >= 40 && pick < 90) begin
            r.mode = (pick < 70) ? MODE_FREE : MODE_RESERVE;
            if ($urandom_range(0, 9) == 0)
                f = $urandom_range(0, total + 1);
            else
                f = $urandom_range(0, near + 1);
            r.addr = f * PAGE_BYTES + $urandom_range(0, PAGE_BYTES - 1);
        end else if (pick >= 90 && pick < 95) begin
            r.mode = (pick < 93) ? MODE_FREE : MODE_RESERVE;
        end else if (pick >= 95) begin
            r.mode = MODE_UNUSED;
        end
        return r;
    endfunction

    // offer one request, with random idle cycles ahead of it
    task automatic send_request(input bfa_req_t r);
        while (!no_idle && $urandom_range(0, 99) < IDLE_PERCENT) begin
            @(negedge clk);
            req_valid <= 1'b0;
        end
        @(negedge clk);
        req_valid <= 1'b1;
        req       <= r;
        @(posedge clk);
        while (!req_ready) @(posedge clk);
        sb.apply_request(r);
    endtask

    // stop offering and wait for every outstanding response
    task automatic drain();
        @(negedge clk);
        req_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_total(input logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        sb.set_total(value);
    endtask

    // response side: random back-pressure, or one long hold-off on request
    initial
    begin : rsp_side
        int unsigned i;
        rsp_ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_rsp) begin
                rsp_ready <= 1'b0;
                for (i = 1; i < HOLD_CYCLES; i++) @(negedge clk);
                hold_rsp = 1'b0;
            end else begin
                rsp_ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PERCENT);
            end
        end
    end

    // response checking and stall watchdog
    initial
    begin : monitor
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge clk);
            if (rst_n && rsp_valid && rsp_ready)
                sb.check_response(rsp);
            if (rst_n && ((req_valid && req_ready) || (rsp_valid && rsp_ready)))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAILURE");
        $finish;
    end

    // stimulus
    initial
    begin : stimulus
        int unsigned p;
        int unsigned n;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        req_valid = 1'b0;
        req       = '0;
        hold_rsp  = 1'b0;
        no_idle   = 1'b0;
        phase_totals = '{16'd40, 16'd70, 16'd1, 16'd130, 16'hFFFF, 16'd32768,
                         16'd300, 16'd5, 16'd0};
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // frame total still zero: nothing can be allocated, freed or reserved
        send_request(make_req(MODE_ALLOC, 32'h0));
        send_request(make_req(MODE_FREE, 32'h0));
        send_request(make_req(MODE_RESERVE, 32'h0));
        send_request(make_req(MODE_UNUSED, 32'hFFFF_FFFF));

        // total above the map size acts as the full map
        drain();
        write_total(16'hFFFF);
        send_request(make_req(MODE_ALLOC, 32'hFFFF_FFFF));
        send_request(make_req(MODE_ALLOC, 32'h0));
        send_request(make_req(MODE_RESERVE, 32'hFFFF_FFFF));
        send_request(make_req(MODE_RESERVE, 32'h07FF_FFFF));
        send_request(make_req(MODE_RESERVE, 32'h07FF_F000));
        send_request(make_req(MODE_FREE, 32'h07FF_F000));
        send_request(make_req(MODE_FREE, 32'h07FF_F123));
        send_request(make_req(MODE_FREE, 32'h0800_0000));
        send_request(make_req(MODE_UNUSED, 32'h0));
        send_request(make_req(MODE_FREE, 32'h0));
        send_request(make_req(MODE_ALLOC, 32'h5555_AAAA));
        send_request(make_req(MODE_RESERVE, 32'h0000_2FFF));

        // tiny total: alloc runs out of frames
        drain();
        write_total(16'd2);
        send_request(make_req(MODE_ALLOC, 32'h0));
        send_request(make_req(MODE_FREE, 32'h0000_1000));
        send_request(make_req(MODE_ALLOC, 32'h0));
        send_request(make_req(MODE_ALLOC, 32'h0));

        // total below the used frames: free count saturates, high bits stay set
        drain();
        write_total(16'd1);
        send_request(make_req(MODE_ALLOC, 32'h0));
        send_request(make_req(MODE_RESERVE, 32'h0000_1000));
        send_request(make_req(MODE_FREE, 32'h0000_2000));

        // random phases across several frame totals
        for (p = 0; p < PHASE_COUNT; p++) begin
            drain();
            write_total(phase_totals[p]);
            hold_rsp = (p == 1);
            no_idle  = (p == 3);
            for (n = 0; n < PHASE_ITEMS; n++) begin
                if (p == 4 && n == PHASE_ITEMS / 2)
                    drain();
                send_request(random_request(phase_totals[p]));
            end
        end
        no_idle = 1'b0;

        // let the last transfers complete
        drain();
        repeat (20) @(posedge clk);
        if (sb.mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
